FILE: sv/fcc_pkg.sv
// Shared types, register map and reset values for the foot contact classifier.
// No dependencies; used by every other file of the block.
package fcc_pkg;

  localparam int NUM_FEET = 2;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  typedef logic [19:0]        force_t;
  typedef logic signed [15:0] height_t;
  typedef logic [16:0]        alpha_t;
  typedef logic [14:0]        margin_t;
  typedef logic [2:0]         reg_idx_t;

  localparam alpha_t ALPHA_ONE = 17'd65536;

  localparam reg_idx_t REG_FILTER_ALPHA     = 3'd0;
  localparam reg_idx_t REG_FORCE_ON_LEVEL   = 3'd1;
  localparam reg_idx_t REG_FORCE_OFF_LEVEL  = 3'd2;
  localparam reg_idx_t REG_MAX_VALID_FORCE  = 3'd3;
  localparam reg_idx_t REG_HEIGHT_TOLERANCE = 3'd4;
  localparam reg_idx_t REG_RELEASE_HEIGHT   = 3'd5;
  localparam reg_idx_t REG_HEIGHT_GUARD_ON  = 3'd6;

  localparam alpha_t  RST_FILTER_ALPHA     = 17'd13107;
  localparam force_t  RST_FORCE_ON_LEVEL   = 20'd1600;
  localparam force_t  RST_FORCE_OFF_LEVEL  = 20'd800;
  localparam force_t  RST_MAX_VALID_FORCE  = 20'd16000;
  localparam margin_t RST_HEIGHT_TOLERANCE = 15'd300;
  localparam margin_t RST_RELEASE_HEIGHT   = 15'd500;
  localparam logic    RST_HEIGHT_GUARD_ON  = 1'b1;

  typedef struct packed {
    alpha_t  filter_alpha;
    force_t  force_on_level;
    force_t  force_off_level;
    force_t  max_valid_force;
    margin_t height_tolerance;
    margin_t release_height;
    logic    height_guard_on;
  } cfg_t;

  typedef struct packed {
    force_t  force_left;
    force_t  force_right;
    height_t height_left;
    height_t height_right;
  } in_item_t;

  typedef struct packed {
    force_t filtered_left;
    force_t filtered_right;
    force_t threshold_left;
    force_t threshold_right;
    logic   contact_left;
    logic   contact_right;
    logic   touchdown_left;
    logic   touchdown_right;
  } out_item_t;

  typedef struct packed {
    force_t filtered;
    force_t threshold;
    logic   contact;
    logic   touchdown;
  } lane_out_t;

endpackage

FILE: sv/fcc_if.sv
// Valid/ready channel interfaces for samples and results.
// Depends on fcc_pkg for the payload types.
interface fcc_in_if;
  logic                valid;
  logic                ready;
  fcc_pkg::in_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fcc_out_if;
  logic                valid;
  logic                ready;
  fcc_pkg::out_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/fcc_regs.sv
// APB-style configuration register file of the foot contact classifier.
// Depends on fcc_pkg for the register map, reset values and cfg_t.
module fcc_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fcc_pkg::ADDR_W-1:0]   paddr,
  input  logic [fcc_pkg::DATA_W-1:0]   pwdata,
  output logic [fcc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output fcc_pkg::cfg_t                cfg
);

  fcc_pkg::reg_idx_t idx;
  logic              wr;

  assign idx   = paddr[fcc_pkg::ADDR_W-1:2];
  assign wr    = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_alpha     <= fcc_pkg::RST_FILTER_ALPHA;
      cfg.force_on_level   <= fcc_pkg::RST_FORCE_ON_LEVEL;
      cfg.force_off_level  <= fcc_pkg::RST_FORCE_OFF_LEVEL;
      cfg.max_valid_force  <= fcc_pkg::RST_MAX_VALID_FORCE;
      cfg.height_tolerance <= fcc_pkg::RST_HEIGHT_TOLERANCE;
      cfg.release_height   <= fcc_pkg::RST_RELEASE_HEIGHT;
      cfg.height_guard_on  <= fcc_pkg::RST_HEIGHT_GUARD_ON;
    end else if (wr) begin
      case (idx)
        fcc_pkg::REG_FILTER_ALPHA:     cfg.filter_alpha     <= pwdata[16:0];
        fcc_pkg::REG_FORCE_ON_LEVEL:   cfg.force_on_level   <= pwdata[19:0];
        fcc_pkg::REG_FORCE_OFF_LEVEL:  cfg.force_off_level  <= pwdata[19:0];
        fcc_pkg::REG_MAX_VALID_FORCE:  cfg.max_valid_force  <= pwdata[19:0];
        fcc_pkg::REG_HEIGHT_TOLERANCE: cfg.height_tolerance <= pwdata[14:0];
        fcc_pkg::REG_RELEASE_HEIGHT:   cfg.release_height   <= pwdata[14:0];
        fcc_pkg::REG_HEIGHT_GUARD_ON:  cfg.height_guard_on  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      fcc_pkg::REG_FILTER_ALPHA:     prdata = {15'd0, cfg.filter_alpha};
      fcc_pkg::REG_FORCE_ON_LEVEL:   prdata = {12'd0, cfg.force_on_level};
      fcc_pkg::REG_FORCE_OFF_LEVEL:  prdata = {12'd0, cfg.force_off_level};
      fcc_pkg::REG_MAX_VALID_FORCE:  prdata = {12'd0, cfg.max_valid_force};
      fcc_pkg::REG_HEIGHT_TOLERANCE: prdata = {17'd0, cfg.height_tolerance};
      fcc_pkg::REG_RELEASE_HEIGHT:   prdata = {17'd0, cfg.release_height};
      fcc_pkg::REG_HEIGHT_GUARD_ON:  prdata = {31'd0, cfg.height_guard_on};
      default:                       prdata = '0;
    endcase
  end

endmodule

FILE: sv/fcc_lane.sv
// One foot: exponential force filter, hysteresis thresholds and height guard.
// Holds the foot's filter value and previous contact flag. Depends on fcc_pkg.
module fcc_lane (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 load,
  input  fcc_pkg::cfg_t        cfg,
  input  fcc_pkg::force_t      raw,
  input  fcc_pkg::height_t     height,
  input  fcc_pkg::height_t     lowest,
  output fcc_pkg::lane_out_t   res
);

  fcc_pkg::force_t    filtered;
  logic               was;
  fcc_pkg::alpha_t    alpha;
  logic signed [20:0] diff;
  logic signed [38:0] prod;
  logic [22:0]        sum;
  fcc_pkg::force_t    filtered_next;
  fcc_pkg::margin_t   margin;
  logic signed [16:0] limit;
  logic               height_ok;
  logic               active;

  assign alpha = (cfg.filter_alpha > fcc_pkg::ALPHA_ONE) ? fcc_pkg::ALPHA_ONE
                                                          : cfg.filter_alpha;
  // f' = f + floor(a * (x - f) / 2^16), same as the weighted form truncated
  assign diff = $signed({1'b0, raw}) - $signed({1'b0, filtered});
  assign prod = $signed({1'b0, alpha}) * diff;
  assign sum  = {3'd0, filtered} + prod[38:16];
  assign filtered_next = load ? raw : sum[19:0];

  assign margin    = was ? cfg.release_height : cfg.height_tolerance;
  assign limit     = $signed({lowest[15], lowest}) + $signed({2'b00, margin});
  assign height_ok = !cfg.height_guard_on || ($signed({height[15], height}) <= limit);
  assign active    = height_ok && (filtered_next <= cfg.max_valid_force) &&
                     (filtered_next >= res.threshold);

  assign res.filtered  = filtered_next;
  assign res.threshold = was ? cfg.force_off_level : cfg.force_on_level;
  assign res.contact   = active;
  assign res.touchdown = active & ~was;

  always_ff @(posedge clk) begin
    if (rst) begin
      filtered <= '0;
      was      <= 1'b0;
    end else if (push) begin
      filtered <= filtered_next;
      was      <= active;
    end
  end

endmodule

FILE: sv/fcc_merge.sv
// Combines the lane results into one result item and buffers it in a
// two-entry output register with skid stage. Depends on fcc_pkg and fcc_if.
module fcc_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                ready,
  input  fcc_pkg::lane_out_t  lanes [fcc_pkg::NUM_FEET],
  fcc_out_if.source           result
);

  fcc_pkg::out_item_t item;
  fcc_pkg::out_item_t skid_data;
  logic               skid_valid;
  logic               take;

  assign item.filtered_left   = lanes[0].filtered;
  assign item.filtered_right  = lanes[1].filtered;
  assign item.threshold_left  = lanes[0].threshold;
  assign item.threshold_right = lanes[1].threshold;
  assign item.contact_left    = lanes[0].contact;
  assign item.contact_right   = lanes[1].contact;
  assign item.touchdown_left  = lanes[0].touchdown;
  assign item.touchdown_right = lanes[1].touchdown;

  assign ready = ~skid_valid;
  assign take  = ~result.valid | result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        result.valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result.valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid) begin
        result.data <= skid_data;
      end else if (push) begin
        result.data <= item;
      end
    end else if (push) begin
      skid_data <= item;
    end
  end

endmodule

FILE: sv/foot_contact_classifier_core.sv
// Foot contact classifier: per-foot exponential force filter and hysteresis contact
// decision with a height guard against the lower foot. One sample is taken per clock
// cycle while the skid entry is empty. Its result is registered in the two-entry
// output buffer, in the output register or, while the output stalls, the skid entry.
// Each lane's filter update is combinational (one 18x21 multiply, add and compares).
// Depends on fcc_pkg, fcc_if, fcc_regs, fcc_lane and fcc_merge.
module foot_contact_classifier_core (
  input  logic                         clk,
  input  logic                         rst,
  fcc_in_if.sink                       sample,
  fcc_out_if.source                    result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fcc_pkg::ADDR_W-1:0]   paddr,
  input  logic [fcc_pkg::DATA_W-1:0]   pwdata,
  output logic [fcc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  fcc_pkg::cfg_t      cfg;
  fcc_pkg::force_t    raw    [fcc_pkg::NUM_FEET];
  fcc_pkg::height_t   height [fcc_pkg::NUM_FEET];
  fcc_pkg::lane_out_t lanes  [fcc_pkg::NUM_FEET];
  fcc_pkg::height_t   lowest;
  logic               ready;
  logic               push;
  logic               seen_sample;

  assign sample.ready = ready;
  assign push = sample.valid & ready;

  assign raw[0]    = sample.data.force_left;
  assign raw[1]    = sample.data.force_right;
  assign height[0] = sample.data.height_left;
  assign height[1] = sample.data.height_right;
  assign lowest    = (height[0] < height[1]) ? height[0] : height[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_sample <= 1'b0;
    end else if (push) begin
      seen_sample <= 1'b1;
    end
  end

  fcc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  for (genvar i = 0; i < fcc_pkg::NUM_FEET; i++) begin : g_lane
    fcc_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .push   (push),
      .load   (~seen_sample),
      .cfg    (cfg),
      .raw    (raw[i]),
      .height (height[i]),
      .lowest (lowest),
      .res    (lanes[i])
    );
  end

  fcc_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .ready  (ready),
    .lanes  (lanes),
    .result (result)
  );

endmodule

FILE: test/tb_foot_contact_classifier_core.sv
// Self-checking testbench for foot_contact_classifier_core: valid/ready driver and monitor,
// APB register writes, and a cycle-free predictor of the filter and contact decision.
// Depends on fcc_pkg, fcc_if and the classifier RTL.
module tb_foot_contact_classifier_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 4000;

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [fcc_pkg::ADDR_W-1:0] paddr;
  logic [fcc_pkg::DATA_W-1:0] pwdata;
  logic [fcc_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  fcc_in_if  sample_if ();
  fcc_out_if result_if ();

  foot_contact_classifier_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_if),
    .result  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fcc_pkg::in_item_t  pending_samples[$];
  fcc_pkg::out_item_t expected_results[$];

  fcc_pkg::cfg_t   cur_cfg;
  fcc_pkg::force_t filt_force [fcc_pkg::NUM_FEET];
  logic            in_contact [fcc_pkg::NUM_FEET];
  logic            primed;

  bit sender_idles;
  bit receiver_idles;
  bit pause_enable;
  logic pausing;
  int gap_left;
  int stall_left;
  int quiet_cycles;

  int fail_count;
  int samples_sent;
  int results_checked;
  int settings_applied;
  int touchdowns_seen;

  bit stance [fcc_pkg::NUM_FEET];
  int dwell [fcc_pkg::NUM_FEET];
  int ground;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void queue_sample(fcc_pkg::in_item_t s);
    pending_samples.insert(pending_samples.size(), s);
  endfunction

  function automatic fcc_pkg::out_item_t predict_contact(fcc_pkg::in_item_t s);
    fcc_pkg::force_t    raw [fcc_pkg::NUM_FEET];
    int                 hgt [fcc_pkg::NUM_FEET];
    int                 lowest;
    int                 margin;
    logic [63:0]        a;
    logic [63:0]        acc;
    fcc_pkg::force_t    f;
    fcc_pkg::force_t    thr;
    logic               height_ok;
    logic               active;
    logic               down;
    fcc_pkg::out_item_t r;
    raw[0] = s.force_left;
    raw[1] = s.force_right;
    hgt[0] = $signed(s.height_left);
    hgt[1] = $signed(s.height_right);
    lowest = (hgt[0] < hgt[1]) ? hgt[0] : hgt[1];
    a = (cur_cfg.filter_alpha > fcc_pkg::ALPHA_ONE) ? 64'(fcc_pkg::ALPHA_ONE)
                                                    : 64'(cur_cfg.filter_alpha);
    r = '0;
    for (int k = 0; k < fcc_pkg::NUM_FEET; k++) begin
      if (!primed) begin
        f = raw[k];
      end else begin
        acc = a * 64'(raw[k]) + (64'd65536 - a) * 64'(filt_force[k]);
        f = acc[35:16];
      end
      filt_force[k] = f;
      thr = in_contact[k] ? cur_cfg.force_off_level : cur_cfg.force_on_level;
      margin = in_contact[k] ? int'(cur_cfg.release_height) : int'(cur_cfg.height_tolerance);
      height_ok = !cur_cfg.height_guard_on || (hgt[k] <= lowest + margin);
      active = height_ok && (f <= cur_cfg.max_valid_force) && (f >= thr);
      down = active && !in_contact[k];
      if (k == 0) begin
        r.filtered_left  = f;
        r.threshold_left = thr;
        r.contact_left   = active;
        r.touchdown_left = down;
      end else begin
        r.filtered_right  = f;
        r.threshold_right = thr;
        r.contact_right   = active;
        r.touchdown_right = down;
      end
      in_contact[k] = active;
    end
    primed = 1'b1;
    return r;
  endfunction

  function automatic void check_field(string name, logic [19:0] want, logic [19:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic fcc_pkg::in_item_t make_sample(int fl, int fr, int hl, int hr);
    fcc_pkg::in_item_t s;
    s.force_left   = 20'(fl);
    s.force_right  = 20'(fr);
    s.height_left  = 16'(hl);
    s.height_right = 16'(hr);
    return s;
  endfunction

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic fcc_pkg::in_item_t noise_sample();
    return make_sample($urandom_range(0, 1048575), $urandom_range(0, 1048575),
                       int'($urandom), int'($urandom));
  endfunction

  // Alternate each foot between stance and swing with force and height to match.
  function automatic fcc_pkg::in_item_t walk_sample();
    int frc [fcc_pkg::NUM_FEET];
    int hgt [fcc_pkg::NUM_FEET];
    longint hi;
    for (int k = 0; k < fcc_pkg::NUM_FEET; k++) begin
      if (dwell[k] == 0) begin
        stance[k] = !stance[k];
        dwell[k] = $urandom_range(3, 25);
      end
      dwell[k]--;
      if (stance[k]) begin
        hi = longint'(cur_cfg.max_valid_force) + cur_cfg.max_valid_force / 8 + 8;
        if (hi > 1048575) hi = 1048575;
        frc[k] = $urandom_range(cur_cfg.force_on_level / 2, int'(hi));
        hgt[k] = clamp16(ground + int'($urandom_range(0, cur_cfg.height_tolerance
                 + cur_cfg.height_tolerance / 2 + 20)));
      end else begin
        frc[k] = $urandom_range(0, cur_cfg.force_off_level + cur_cfg.force_off_level / 4);
        hgt[k] = clamp16(ground + int'($urandom_range(0, 4 * cur_cfg.release_height + 200)));
      end
    end
    return make_sample(frc[0], frc[1], hgt[0], hgt[1]);
  endfunction

  function automatic fcc_pkg::cfg_t rand_cfg();
    fcc_pkg::cfg_t c;
    int r;
    longint m;
    r = $urandom_range(0, 99);
    if (r < 70) c.filter_alpha = 17'($urandom_range(8192, 65536));
    else if (r < 85) c.filter_alpha = 17'($urandom_range(1, 8191));
    else c.filter_alpha = 17'($urandom_range(65536, 131071));
    c.force_on_level = 20'($urandom_range(200, 40000));
    if ($urandom_range(0, 99) < 15)
      c.force_off_level = 20'($urandom_range(c.force_on_level, 2 * c.force_on_level));
    else
      c.force_off_level = 20'($urandom_range(c.force_on_level / 4, c.force_on_level));
    m = 6 * longint'(c.force_on_level);
    c.max_valid_force = 20'($urandom_range(c.force_on_level + c.force_on_level / 2, int'(m)));
    c.height_tolerance = 15'($urandom_range(0, 1500));
    if ($urandom_range(0, 9) == 0) c.release_height = 15'($urandom_range(0, 1500));
    else c.release_height = 15'(c.height_tolerance + $urandom_range(0, 1500));
    c.height_guard_on = ($urandom_range(0, 3) != 0);
    return c;
  endfunction

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_samples.size() != 0 || sample_if.valid || pausing
               || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(fcc_pkg::reg_idx_t idx, logic [31:0] value);
    wait_drained();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      fcc_pkg::REG_FILTER_ALPHA:     cur_cfg.filter_alpha     = value[16:0];
      fcc_pkg::REG_FORCE_ON_LEVEL:   cur_cfg.force_on_level   = value[19:0];
      fcc_pkg::REG_FORCE_OFF_LEVEL:  cur_cfg.force_off_level  = value[19:0];
      fcc_pkg::REG_MAX_VALID_FORCE:  cur_cfg.max_valid_force  = value[19:0];
      fcc_pkg::REG_HEIGHT_TOLERANCE: cur_cfg.height_tolerance = value[14:0];
      fcc_pkg::REG_RELEASE_HEIGHT:   cur_cfg.release_height   = value[14:0];
      fcc_pkg::REG_HEIGHT_GUARD_ON:  cur_cfg.height_guard_on  = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(fcc_pkg::cfg_t c);
    write_reg(fcc_pkg::REG_FILTER_ALPHA, 32'(c.filter_alpha));
    write_reg(fcc_pkg::REG_FORCE_ON_LEVEL, 32'(c.force_on_level));
    write_reg(fcc_pkg::REG_FORCE_OFF_LEVEL, 32'(c.force_off_level));
    write_reg(fcc_pkg::REG_MAX_VALID_FORCE, 32'(c.max_valid_force));
    write_reg(fcc_pkg::REG_HEIGHT_TOLERANCE, 32'(c.height_tolerance));
    write_reg(fcc_pkg::REG_RELEASE_HEIGHT, 32'(c.release_height));
    write_reg(fcc_pkg::REG_HEIGHT_GUARD_ON, 32'(c.height_guard_on));
    settings_applied++;
  endtask

  task automatic run_phase(fcc_pkg::cfg_t c, int count, int noise_pct, bit snd_idle,
                           bit rcv_idle, bit pause);
    apply_cfg(c);
    sender_idles   = snd_idle;
    receiver_idles = rcv_idle;
    pause_enable   = pause;
    ground = int'($urandom_range(0, 4000)) - 8000;
    stance[0] = 1'b1;
    stance[1] = 1'b0;
    dwell[0] = $urandom_range(1, 10);
    dwell[1] = $urandom_range(1, 10);
    repeat (count) begin
      if ($urandom_range(0, 99) < noise_pct) queue_sample(noise_sample());
      else queue_sample(walk_sample());
    end
  endtask

  // Sample driver.
  always @(posedge clk) begin
    if (rst) begin
      sample_if.valid <= 1'b0;
      sample_if.data  <= '0;
      gap_left        <= 0;
      pausing         <= 1'b0;
    end else begin
      if (sample_if.valid && sample_if.ready) begin
        expected_results.insert(expected_results.size(), predict_contact(sample_if.data));
        samples_sent++;
      end
      if (sample_if.valid && !sample_if.ready) begin
        // hold the current transfer
      end else if (pausing) begin
        sample_if.valid <= 1'b0;
        if (expected_results.size() == 0) pausing <= 1'b0;
      end else if (gap_left != 0) begin
        sample_if.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_samples.size() != 0) begin
        sample_if.valid <= 1'b1;
        sample_if.data  <= pending_samples.pop_front();
        gap_left <= sender_idles ? pick_gap() : 0;
        if (pause_enable && $urandom_range(0, 39) == 0) pausing <= 1'b1;
      end else begin
        sample_if.valid <= 1'b0;
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    fcc_pkg::out_item_t want;
    int stall;
    if (rst) begin
      result_if.ready <= 1'b0;
      stall_left      <= 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        results_checked++;
        if (result_if.data.touchdown_left || result_if.data.touchdown_right) touchdowns_seen++;
        if (expected_results.size() == 0) begin
          $error("result transfer with no sample outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("filtered_left", want.filtered_left, result_if.data.filtered_left);
          check_field("filtered_right", want.filtered_right, result_if.data.filtered_right);
          check_field("threshold_left", want.threshold_left, result_if.data.threshold_left);
          check_field("threshold_right", want.threshold_right, result_if.data.threshold_right);
          check_field("contact_left", 20'(want.contact_left), 20'(result_if.data.contact_left));
          check_field("contact_right", 20'(want.contact_right),
                      20'(result_if.data.contact_right));
          check_field("touchdown_left", 20'(want.touchdown_left),
                      20'(result_if.data.touchdown_left));
          check_field("touchdown_right", 20'(want.touchdown_right),
                      20'(result_if.data.touchdown_right));
        end
      end
      stall = 0;
      if (stall_left == 0 && receiver_idles && $urandom_range(0, 5) == 0) stall = pick_gap();
      if (stall_left != 0) begin
        result_if.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (stall != 0) begin
        result_if.ready <= 1'b0;
        stall_left <= stall - 1;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)
        || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    fcc_pkg::cfg_t c;
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    sample_if.valid = 1'b0;
    sample_if.data  = '0;
    result_if.ready = 1'b0;
    quiet_cycles    = 0;
    cur_cfg = '{fcc_pkg::RST_FILTER_ALPHA, fcc_pkg::RST_FORCE_ON_LEVEL,
                fcc_pkg::RST_FORCE_OFF_LEVEL, fcc_pkg::RST_MAX_VALID_FORCE,
                fcc_pkg::RST_HEIGHT_TOLERANCE, fcc_pkg::RST_RELEASE_HEIGHT,
                fcc_pkg::RST_HEIGHT_GUARD_ON};
    for (int k = 0; k < fcc_pkg::NUM_FEET; k++) begin
      filt_force[k] = '0;
      in_contact[k] = 1'b0;
    end
    primed = 1'b0;
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: first sample loads the filter, then field extremes.
    queue_sample(make_sample(2000, 100, 0, 0));
    queue_sample(make_sample(1048575, 0, 32767, -32768));
    queue_sample(make_sample(0, 1048575, -32768, 32767));
    queue_sample(make_sample(1048575, 1048575, -32768, -32768));
    queue_sample(make_sample(0, 0, 32767, 32767));

    // Unity weight: hysteresis, release height and the valid ceiling.
    write_reg(fcc_pkg::REG_FILTER_ALPHA, 32'd65536);
    queue_sample(make_sample(1700, 1700, 0, 0));
    queue_sample(make_sample(1000, 1000, 0, 400));
    queue_sample(make_sample(700, 1000, 0, 600));
    queue_sample(make_sample(1000, 1000, 0, 0));
    queue_sample(make_sample(16001, 16000, 0, 0));

    write_reg(fcc_pkg::REG_HEIGHT_GUARD_ON, 32'd0);
    queue_sample(make_sample(2000, 2000, -30000, 30000));

    // Off level above on level.
    write_reg(fcc_pkg::REG_FORCE_ON_LEVEL, 32'd1000);
    write_reg(fcc_pkg::REG_FORCE_OFF_LEVEL, 32'd3000);
    queue_sample(make_sample(1500, 1500, 0, 0));
    queue_sample(make_sample(2500, 3500, 0, 0));

    // Zero weight holds the filter.
    write_reg(fcc_pkg::REG_FILTER_ALPHA, 32'd0);
    queue_sample(make_sample(50000, 0, 0, 0));
    queue_sample(make_sample(0, 1048575, 0, 0));

    // Weights above one saturate, then the smallest nonzero weight.
    write_reg(fcc_pkg::REG_FILTER_ALPHA, 32'd131071);
    queue_sample(make_sample(1234, 98765, 0, 0));
    write_reg(fcc_pkg::REG_FILTER_ALPHA, 32'd65537);
    queue_sample(make_sample(5, 7, 0, 0));
    write_reg(fcc_pkg::REG_FILTER_ALPHA, 32'd1);
    queue_sample(make_sample(1048575, 1048575, 0, 0));

    c = '{fcc_pkg::RST_FILTER_ALPHA, fcc_pkg::RST_FORCE_ON_LEVEL,
          fcc_pkg::RST_FORCE_OFF_LEVEL, fcc_pkg::RST_MAX_VALID_FORCE,
          fcc_pkg::RST_HEIGHT_TOLERANCE, fcc_pkg::RST_RELEASE_HEIGHT,
          fcc_pkg::RST_HEIGHT_GUARD_ON};
    run_phase(c, 150, 15, 1, 1, 1);

    c = rand_cfg();
    c.filter_alpha = fcc_pkg::ALPHA_ONE;
    c.height_guard_on = 1'b1;
    run_phase(c, 150, 10, 0, 0, 0);

    c = rand_cfg();
    c.filter_alpha = 17'd1;
    run_phase(c, 80, 15, 1, 0, 0);

    repeat (6) begin
      run_phase(rand_cfg(), 120, 15, $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0, 1);
    end

    c = '{17'd131071, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 15'h7FFF, 15'h7FFF, 1'b0};
    run_phase(c, 60, 100, 1, 1, 0);

    c = '{fcc_pkg::ALPHA_ONE, 20'd0, 20'd0, 20'd0, 15'd0, 15'd0, 1'b1};
    run_phase(c, 60, 50, 1, 1, 0);

    c = rand_cfg();
    c.filter_alpha = 17'd0;
    run_phase(c, 40, 15, 1, 1, 0);

    c = rand_cfg();
    c.force_off_level = c.force_on_level + 20'($urandom_range(1, 4000));
    run_phase(c, 80, 15, 1, 1, 1);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("covered %0d samples over %0d register settings; %0d results checked",
             samples_sent, settings_applied, results_checked);
    $display("touchdowns observed: %0d", touchdowns_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
